// File: hw/rtl/svl1_pkg.sv
// Package: shared types, constants and float helpers for the sparse level-1 engine.
`timescale 1ns / 1ps
package svl1_pkg;

  localparam int unsigned VectorDepthDefault = 4096;
  localparam int unsigned IndexWidth = 12;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    CmdAxpy    = 2'd0,
    CmdDot     = 2'd1,
    CmdGather  = 2'd2,
    CmdScatter = 2'd3
  } cmd_e;

  // one queued work item from the front end
  typedef struct packed {
    logic [1:0]            cmd;
    logic [IndexWidth-1:0] index;
    logic [31:0]           value;
    logic                  last;
    logic                  in_range;
  } item_t;

  // float multiply, round to nearest even, canonical NaN
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb, sr;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic signed [10:0] e;
    logic [49:0] m;
    logic [5:0]  lz;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [24:0] keep;
    logic        g, st;
    logic signed [10:0] sh;
    logic [31:0] r;
    sa = a[31]; sb = b[31]; sr = sa ^ sb;
    ea = a[30:23]; eb = b[30:23];
    a_nan = (ea == 8'hFF) && (a[22:0] != 0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 0);
    a_inf = (ea == 8'hFF) && (a[22:0] == 0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 0);
    a_zero = (ea == 0) && (a[22:0] == 0);
    b_zero = (eb == 0) && (b[22:0] == 0);
    ma = {(ea != 0), a[22:0]};
    mb = {(eb != 0), b[22:0]};
    p = ma * mb;
    // value = p * 2^(e - 127 - 46), e from effective exponents
    e = 11'(signed'({3'b0, (ea == 0) ? 8'd1 : ea})) +
        11'(signed'({3'b0, (eb == 0) ? 8'd1 : eb})) - 11'sd127;
    lz = 6'd0;
    for (int i = 47; i >= 0; i--) begin
      if (p[i]) begin
        lz = 6'(47 - i);
        break;
      end
    end
    // normalize: leading one to bit 47, exponent e+1-lz
    m = {p << lz, 2'b0};
    e = e + 11'sd1 - 11'(signed'({5'b0, lz}));
    if (e < 11'sd1) begin
      sh = 11'sd1 - e;
      if (sh > 11'sd49) sh = 11'sd49;
      st = |(m & ((50'd1 << sh) - 50'd1));
      m = (m >> sh) | {49'd0, st};
      e = 11'sd0;
    end
    keep = {1'b0, m[49:26]};
    g = m[25];
    st = |m[24:0];
    if (g && (st || keep[0])) keep = keep + 25'd1;
    if (keep[24]) begin
      keep = keep >> 1;
      e = e + 11'sd1;
    end else if (e == 11'sd0 && keep[23]) begin
      e = 11'sd1;
    end
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) r = CanonNan;
    else if (a_inf || b_inf) r = {sr, 8'hFF, 23'd0};
    else if (p == 0) r = {sr, 31'd0};
    else if (e >= 11'sd255) r = {sr, 8'hFF, 23'd0};
    else r = {sr, e[7:0], keep[22:0]};
    return r;
  endfunction

  // float add, round to nearest even, canonical NaN
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y, r;
    logic [7:0]  ex, ey;
    logic [27:0] mx, my, s;
    logic [7:0]  d;
    logic        st, sub;
    logic signed [10:0] e;
    logic [4:0]  lz;
    logic [24:0] keep;
    logic        g, rs;
    if ((a[30:0] >= b[30:0])) begin x = a; y = b; end
    else begin x = b; y = a; end
    ex = x[30:23]; ey = y[30:23];
    // mantissa with 3 guard bits
    mx = {1'b0, (ex != 0), x[22:0], 3'b0};
    my = {1'b0, (ey != 0), y[22:0], 3'b0};
    d = ((ex == 0) ? 8'd1 : ex) - ((ey == 0) ? 8'd1 : ey);
    if (d > 8'd27) begin
      st = (my != 0);
      my = {27'd0, st};
    end else begin
      st = |(my & ((28'd1 << d) - 28'd1));
      my = (my >> d) | {27'd0, st};
    end
    sub = x[31] ^ y[31];
    s = sub ? (mx - my) : (mx + my);
    e = 11'(signed'({3'b0, (ex == 0) ? 8'd1 : ex}));
    if (s[27]) begin
      s = (s >> 1) | {27'd0, s[0]};
      e = e + 11'sd1;
    end else begin
      lz = 5'd0;
      for (int i = 26; i >= 0; i--) begin
        if (s[i]) begin
          lz = 5'(26 - i);
          break;
        end
      end
      if (11'(signed'({6'b0, lz})) > e - 11'sd1) lz = 5'(e - 11'sd1);
      s = s << lz;
      e = e - 11'(signed'({6'b0, lz}));
      if (!s[26]) e = 11'sd0;
    end
    keep = {1'b0, s[26:3]};
    g = s[2];
    rs = |s[1:0];
    if (g && (rs || keep[0])) keep = keep + 25'd1;
    if (keep[24]) begin
      keep = keep >> 1;
      e = e + 11'sd1;
    end else if (e == 11'sd0 && keep[23]) begin
      e = 11'sd1;
    end
    if ((ex == 8'hFF && x[22:0] != 0) || (ey == 8'hFF && y[22:0] != 0)) r = CanonNan;
    else if (ex == 8'hFF) r = (ey == 8'hFF && sub) ? CanonNan : x;
    else if (s == 0) r = (x[31] & y[31]) ? 32'h8000_0000 : 32'h0;
    else if (e >= 11'sd255) r = {x[31], 8'hFF, 23'd0};
    else r = {x[31], e[7:0], keep[22:0]};
    return r;
  endfunction

endpackage

// File: hw/rtl/svl1_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module svl1_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: hw/rtl/svl1_front.sv
// Front end: takes commands, checks range, feeds a small queue.
`timescale 1ns / 1ps
module svl1_front
  import svl1_pkg::*;
#(
  parameter int unsigned VectorDepth = VectorDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] index_i,
  input  logic [31:0] value_i,
  input  logic        last_i,
  input  logic        clear_busy_i,
  output logic        busy_o,
  output logic        q_valid_o,
  output item_t       q_item_o,
  input  logic        q_pop_i
);
  localparam int unsigned PtrW = $clog2(QueueDepth);
  item_t q_mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push;
  item_t           item;

  assign busy_o = (cnt_q == (PtrW+1)'(QueueDepth)) || clear_busy_i;
  assign push   = start_i && !busy_o;

  always_comb begin
    item.cmd      = cmd_i;
    item.index    = index_i;
    item.value    = value_i;
    item.last     = last_i;
    item.in_range = ({20'd0, index_i} < 32'(VectorDepth));
  end

  always_comb begin
    wp_d  = push ? wp_q + 1'b1 : wp_q;
    rp_d  = q_pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= item;
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = q_mem_q[rp_q];
endmodule

// File: hw/rtl/svl1_back.sv
// Back end: store access, multiply, add, write-back and result strobe.
`timescale 1ns / 1ps
module svl1_back
  import svl1_pkg::*;
#(
  parameter int unsigned VectorDepth = VectorDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] alpha_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        clearing_o,
  output logic        idle_o,
  output logic        done_o,
  output logic [31:0] result_value_o,
  output logic [1:0]  result_cmd_o,
  output logic        result_last_o
);
  localparam int unsigned AddrW = $clog2(VectorDepth);
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [AddrW:0]   clr_q, clr_d;
  item_t            it_q;
  logic [31:0]      prod_q, sum_q, dot_q, dot_d, res_q;
  logic             done_q;
  logic [1:0]       rcmd_q;
  logic             rlast_q;
  logic             we;
  logic [AddrW-1:0] addr;
  logic [31:0]      wdata, rdata, entry;

  svl1_ram #(.Width(WordWidth), .Depth(VectorDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign entry = it_q.in_range ? rdata : 32'd0;
  assign q_pop_o = (st_q == StIdle) && q_valid_i;
  assign clearing_o = (st_q == StClear);
  assign idle_o = (st_q == StIdle);

  always_comb begin
    st_d  = st_q;
    clr_d = clr_q;
    dot_d = dot_q;
    we    = 1'b0;
    addr  = AddrW'(it_q.index);
    wdata = sum_q;
    case (st_q)
      StClear: begin
        we    = 1'b1;
        addr  = clr_q[AddrW-1:0];
        wdata = 32'd0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(VectorDepth - 1)) st_d = StIdle;
      end
      StIdle: begin
        addr = AddrW'(q_item_i.index);
        if (q_valid_i) st_d = StRead;
      end
      StRead: begin
        st_d = StMul;
        if (it_q.cmd == CmdScatter) begin
          we    = it_q.in_range;
          wdata = it_q.value;
          st_d  = StIdle;
        end else if (it_q.cmd == CmdGather) begin
          st_d = StIdle;
        end
      end
      StMul: st_d = StAdd;
      StAdd: begin
        st_d = StIdle;
        if (it_q.cmd == CmdAxpy) begin
          we = it_q.in_range;
        end else begin
          dot_d = it_q.last ? 32'd0 : sum_q;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StClear;
      clr_q  <= '0;
      dot_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      clr_q  <= clr_d;
      dot_q  <= dot_d;
      done_q <= ((st_q == StRead) && (it_q.cmd == CmdScatter || it_q.cmd == CmdGather)) ||
                (st_q == StAdd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) it_q <= q_item_i;
    if (st_q == StRead) begin
      prod_q <= fmul(it_q.value, (it_q.cmd == CmdAxpy) ? alpha_i : entry);
      res_q  <= (it_q.cmd == CmdGather) ? entry : it_q.value;
      if (it_q.cmd == CmdAxpy) sum_q <= entry;
      else sum_q <= dot_q;
    end
    if (st_q == StMul) begin
      sum_q <= fadd(sum_q, prod_q);
      res_q <= prod_q;
    end
    if (st_q == StAdd && it_q.cmd == CmdDot) res_q <= sum_q;
    rcmd_q  <= it_q.cmd;
    rlast_q <= it_q.last;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign result_cmd_o   = rcmd_q;
  assign result_last_o  = rlast_q;
endmodule

// File: hw/rtl/sparse_vector_level1_engine_unit.sv
// Top level of the sparse vector level-1 engine (axpy, dot, gather, scatter).
//
//  channel | signals                                   | dir | flow
//  --------+-------------------------------------------+-----+------------------------
//  command | start_i busy_o cmd_i index_i value_i last_i | in  | word taken: start & !busy
//  result  | done_o result_value_o result_cmd_o ...     | out | one-cycle strobe, no stall
//  config  | cfg_valid_i cfg_ready_o cfg_data_i        | in  | alpha written: valid & ready
//
// The back end holds a word in idle and read for gather and scatter, and in idle, read,
// multiply and add for axpy and dot; the store's single RAM port and the serial read,
// multiply, add, write-back loop set this. The result strobe is registered as the last state ends.
// The front queue holds two words so commands are taken while the back end works.
// After reset the store is swept to zero, entry by entry, with busy held high.
// Results cannot be stalled; each shows for exactly one cycle with done_o.
`timescale 1ns / 1ps
module sparse_vector_level1_engine_unit
  import svl1_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = VectorDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] index_i,
  input  logic [31:0] value_i,
  input  logic        last_i,
  output logic        done_o,
  output logic [31:0] result_value_o,
  output logic [1:0]  result_cmd_o,
  output logic        result_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  logic [31:0] alpha_q;
  logic        q_valid, q_pop, clearing, idle;
  item_t       q_item;

  // alpha register; always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) alpha_q <= '0;
    else if (cfg_valid_i) alpha_q <= cfg_data_i;
  end

  svl1_front #(.VectorDepth(VECTOR_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .last_i      (last_i),
    .clear_busy_i(clearing),
    .busy_o      (busy_o),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  svl1_back #(.VectorDepth(VECTOR_DEPTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .alpha_i       (alpha_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .clearing_o    (clearing),
    .idle_o        (idle),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .result_cmd_o  (result_cmd_o),
    .result_last_o (result_last_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> busy_o) else $error("command taken during store sweep");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (idle && q_valid)) else $error("pop outside idle");
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back result strobes");
`endif
endmodule

// File: tb/sparse_vector_level1_engine_unit_tb.sv
// Testbench for the sparse vector level-1 engine: bit-exact float predictor and scoreboard.
`timescale 1ns / 1ps
module sparse_vector_level1_engine_unit_tb;
  import svl1_pkg::*;

  // Predicts every result word of the engine and checks the result stream in order.
  class sparse_result_board;
    typedef struct {
      logic [31:0] value;
      logic [1:0]  cmd;
      logic        last;
    } word_t;

    logic [31:0] vec_mem [4096];
    logic [31:0] alpha;
    logic [31:0] dot_acc;
    word_t       pending_q [$];
    int          errors;

    function new();
      foreach (vec_mem[i]) vec_mem[i] = 32'h0;
      alpha   = 32'h0;
      dot_acc = 32'h0;
      errors  = 0;
    endfunction

    // Round mag * 2^ex to binary32, nearest even; mag must be nonzero.
    static function logic [31:0] round_pack(logic sgn, logic [299:0] mag, int ex);
      int          msb;
      int          q;
      int          lsb_exp;
      logic [299:0] fr;
      logic        g;
      logic        st;
      logic [63:0] f;
      msb = 0;
      for (int i = 299; i >= 0; i--) begin
        if (mag[i]) begin
          msb = i;
          break;
        end
      end
      q = msb - 23;
      if (msb + ex < -126) q = -149 - ex;  // subnormal: lsb weight fixed at 2^-149
      if (q <= 0) begin
        fr = mag << (-q);
        g  = 1'b0;
        st = 1'b0;
      end else begin
        fr = mag >> q;
        g  = mag[q-1];
        st = (q > 1) ? |(mag & ((300'd1 << (q - 1)) - 300'd1)) : 1'b0;
      end
      if (g && (st || fr[0])) fr = fr + 300'd1;
      lsb_exp = q + ex;
      // hidden bit carries into the exponent field, so carry-out and subnormal-to-normal work
      f = (64'(lsb_exp + 149) << 23) + fr[63:0];
      if (f >= 64'h7F80_0000) return {sgn, 8'hFF, 23'd0};
      return {sgn, f[30:0]};
    endfunction

    static function logic [31:0] mul_f32(logic [31:0] a, logic [31:0] b);
      logic        s;
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [299:0] mag;
      int          ea, eb;
      s      = a[31] ^ b[31];
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 0);
      a_zero = (a[30:0] == 0);
      b_zero = (b[30:0] == 0);
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return CanonNan;
      if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
      if (a_zero || b_zero) return {s, 31'd0};
      ea  = (a[30:23] == 0) ? 1 : int'(a[30:23]);
      eb  = (b[30:23] == 0) ? 1 : int'(b[30:23]);
      mag = 300'({a[30:23] != 0, a[22:0]}) * 300'({b[30:23] != 0, b[22:0]});
      return round_pack(s, mag, ea + eb - 300);
    endfunction

    static function logic [31:0] add_f32(logic [31:0] a, logic [31:0] b);
      logic        a_inf, b_inf, s;
      logic [299:0] ma, mb, mag;
      int          ea, eb, emin;
      if (((a[30:23] == 8'hFF) && (a[22:0] != 0)) || ((b[30:23] == 8'hFF) && (b[22:0] != 0)))
        return CanonNan;
      a_inf = (a[30:23] == 8'hFF);
      b_inf = (b[30:23] == 8'hFF);
      if (a_inf && b_inf && (a[31] != b[31])) return CanonNan;
      if (a_inf) return a;
      if (b_inf) return b;
      ea   = (a[30:23] == 0) ? 1 : int'(a[30:23]);
      eb   = (b[30:23] == 0) ? 1 : int'(b[30:23]);
      emin = (ea < eb) ? ea : eb;
      ma   = 300'({a[30:23] != 0, a[22:0]}) << (ea - emin);
      mb   = 300'({b[30:23] != 0, b[22:0]}) << (eb - emin);
      if (a[31] == b[31]) begin
        mag = ma + mb;
        s   = a[31];
      end else if (ma > mb) begin
        mag = ma - mb;
        s   = a[31];
      end else begin
        mag = mb - ma;
        s   = b[31];
      end
      if (mag == 0) return (a[31] & b[31]) ? 32'h8000_0000 : 32'h0;
      return round_pack(s, mag, emin - 150);
    endfunction

    function void note_word(cmd_e c, logic [11:0] idx, logic [31:0] v, logic l);
      word_t       w;
      logic [31:0] entry;
      logic [31:0] scaled;
      entry = vec_mem[idx];
      case (c)
        CmdAxpy: begin
          scaled       = mul_f32(v, alpha);
          vec_mem[idx] = add_f32(entry, scaled);
          w.value      = scaled;
        end
        CmdDot: begin
          dot_acc = add_f32(dot_acc, mul_f32(v, entry));
          w.value = dot_acc;
          if (l) dot_acc = 32'h0;
        end
        CmdGather: w.value = entry;
        default: begin
          vec_mem[idx] = v;
          w.value      = v;
        end
      endcase
      w.cmd  = c;
      w.last = l;
      pending_q.push_back(w);
    endfunction

    function void check_word(logic [31:0] v, logic [1:0] c, logic l);
      word_t w;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result value=%h cmd=%0d", v, c);
        return;
      end
      w = pending_q.pop_front();
      if (v !== w.value || c !== w.cmd || l !== w.last) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: exp value=%h cmd=%0d last=%b, got value=%h cmd=%0d last=%b",
                   w.value, w.cmd, w.last, v, c, l);
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  cmd_i;
  logic [11:0] index_i;
  logic [31:0] value_i;
  logic        last_i;
  logic        done_o;
  logic [31:0] result_value_o;
  logic [1:0]  result_cmd_o;
  logic        result_last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;

  sparse_result_board board = new();
  int idle_pct;

  sparse_vector_level1_engine_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .last_i        (last_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .result_cmd_o  (result_cmd_o),
    .result_last_o (result_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Results cannot be held off: take every strobe as it comes.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_word(result_value_o, result_cmd_o, result_last_o);
  end

  // Run limit: worst case is far below this (store sweep plus ~1500 slow words).
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Drive one command word; optional random gap before it.
  task automatic send_word(cmd_e c, logic [11:0] idx, logic [31:0] v, logic l);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    cmd_i   = c;
    index_i = idx;
    value_i = v;
    last_i  = l;
    do @(posedge clk_i); while (busy_o);
    board.note_word(c, idx, v, l);
  endtask

  // Hold off until every expected word has come, then let the back end settle.
  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_alpha(logic [31:0] a);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = a;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.alpha = a;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] specials [10] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                   32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001,
                                   32'h807F_FFFF, 32'h7F7F_FFFF, 32'h0080_0000};
    case ($urandom_range(0, 7))
      3:       return $urandom;
      4:       return specials[$urandom_range(0, 9)];
      5:       return {1'($urandom), 8'h00, 23'($urandom)};
      6:       return {1'($urandom), 8'($urandom_range(230, 254)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    endcase
  endfunction

  initial begin
    logic [31:0] alpha_set [6] = '{32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001,
                                   32'hFFFF_FFFF, 32'hC040_0000, 32'h0};
    logic [11:0] idx;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = CmdAxpy;
    index_i     = '0;
    value_i     = '0;
    last_i      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    idle_pct    = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: store ends, field extremes, alpha at reset (+0), dot run end, NaN/inf/subnormal
    send_word(CmdGather,  12'd0,    32'h0,         1'b1);
    send_word(CmdGather,  12'hFFF,  32'hFFFF_FFFF, 1'b0);
    send_word(CmdScatter, 12'd0,    32'h3FC0_0000, 1'b0);
    send_word(CmdScatter, 12'hFFF,  32'hFFFF_FFFF, 1'b1);
    send_word(CmdScatter, 12'd1,    32'h0000_0001, 1'b0);
    send_word(CmdScatter, 12'd2,    32'h7F80_0000, 1'b0);
    send_word(CmdAxpy,    12'd0,    32'h4000_0000, 1'b0);
    send_word(CmdAxpy,    12'd2,    32'hFF80_0000, 1'b1);
    send_word(CmdGather,  12'd2,    32'h0,         1'b0);
    send_word(CmdDot,     12'd0,    32'h4000_0000, 1'b0);
    send_word(CmdDot,     12'd0,    32'h4000_0000, 1'b1);
    send_word(CmdDot,     12'hFFF,  32'h3F80_0000, 1'b0);
    send_word(CmdDot,     12'd0,    32'h3F80_0000, 1'b1);
    send_word(CmdDot,     12'd1,    32'h0000_0001, 1'b1);
    send_word(CmdDot,     12'd2,    32'h0,         1'b1);
    send_word(CmdGather,  12'hFFF,  32'h0,         1'b1);
    drain_results();
    write_alpha(32'h3F80_0000);
    send_word(CmdAxpy,    12'd0,    32'h3F80_0000, 1'b0);
    send_word(CmdAxpy,    12'd1,    32'h8000_0001, 1'b0);
    send_word(CmdAxpy,    12'd3,    32'h7F7F_FFFF, 1'b0);
    send_word(CmdAxpy,    12'd3,    32'h7F7F_FFFF, 1'b0);
    send_word(CmdGather,  12'd1,    32'h0,         1'b0);
    send_word(CmdGather,  12'd3,    32'h0,         1'b0);
    drain_results();

    // random phases: sender idles 22%, then 88%, then never
    for (int ph = 0; ph < 6; ph++) begin
      write_alpha(alpha_set[ph] == 32'h0 ? $urandom : alpha_set[ph]);
      idle_pct = (ph < 2) ? 22 : (ph < 4) ? 88 : 0;
      for (int n = 0; n < 250; n++) begin
        idx = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 15)) : 12'($urandom);
        send_word(cmd_e'($urandom_range(0, 3)), idx, pick_value(),
                  $urandom_range(0, 3) == 0);
      end
      drain_results();
    end

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/svl1_pkg.sv
hw/rtl/svl1_ram.sv
hw/rtl/svl1_front.sv
hw/rtl/svl1_back.sv
hw/rtl/sparse_vector_level1_engine_unit.sv
tb/sparse_vector_level1_engine_unit_tb.sv
